// ===== sv/ctp_pkg.sv =====
// Package: constants, state type and helpers for the compact timestamp parser.
package ctp_pkg;

  localparam int unsigned TailDigits    = 10;
  localparam int unsigned MaxYearDigits = 9;
  localparam int unsigned MaxDigits     = TailDigits + MaxYearDigits;
  localparam int unsigned CountWidth    = 5;
  localparam int unsigned AccumWidth    = 30;
  localparam int unsigned YearWidth     = 31;
  localparam int unsigned FieldWidth    = 7;
  localparam int unsigned LengthWidth   = 5;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [CountWidth-1:0] CountTail = CountWidth'(TailDigits);
  localparam logic [CountWidth-1:0] CountMax  = CountWidth'(MaxDigits);
  localparam logic [CountWidth-1:0] CountSat  = {CountWidth{1'b1}};

  typedef logic [3:0] digit_t;

  typedef struct packed {
    digit_t [TailDigits-1:0]  window;
    logic [CountWidth-1:0]    count;
    logic [AccumWidth-1:0]    accum;
    logic                     negative;
    logic                     at_start;
    logic                     error_seen;
  } scan_state_t;

  function automatic logic [FieldWidth-1:0] pair_value(digit_t hi, digit_t lo);
    logic [FieldWidth-1:0] h;
    h = FieldWidth'(hi);
    return (h << 3) + (h << 1) + FieldWidth'(lo);
  endfunction

endpackage

// ===== sv/ctp_scan.sv =====
// Character scanner: digit window, digit count, year accumulator and flags.
module ctp_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          char_in_i,
  input  logic                last_char_i,
  output ctp_pkg::scan_state_t state_d_o
);
  import ctp_pkg::*;

  scan_state_t state_q;
  scan_state_t state_d;
  scan_state_t reset_state;
  logic        is_digit;
  digit_t      digit;
  logic [CountWidth-1:0] count_inc;

  assign is_digit = (char_in_i >= CharZero) && (char_in_i <= CharNine);
  assign digit    = 4'(char_in_i - CharZero);

  always_comb begin
    reset_state            = '0;
    reset_state.at_start   = 1'b1;
  end

  always_comb begin
    state_d          = state_q;
    state_d.at_start = 1'b0;
    count_inc        = state_q.count;
    if (!state_q.error_seen) begin
      if (state_q.at_start && char_in_i == CharMinus) begin
        state_d.negative = 1'b1;
      end else if (!is_digit) begin
        state_d.error_seen = 1'b1;
      end else begin
        if (state_q.count >= CountTail) begin
          state_d.accum = (state_q.accum << 3) + (state_q.accum << 1)
                          + AccumWidth'(state_q.window[0]);
        end
        state_d.window = {digit, state_q.window[TailDigits-1:1]};
        if (state_q.count != CountSat) begin
          count_inc = state_q.count + 1'b1;
        end
        state_d.count = count_inc;
        if (count_inc > CountMax) begin
          state_d.error_seen = 1'b1;
        end
      end
    end
  end

  assign state_d_o = state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= reset_state;
    end else if (accept_i) begin
      state_q <= last_char_i ? reset_state : state_d;
    end
  end

endmodule

// ===== sv/compact_timestamp_parser.sv =====
// Top level: compact timestamp parser with a registered result.
//
//   channel | signals                        | handshake
//   in      | char_in_i, last_char_i         | in_valid_i / in_ready_o
//   out     | parse_ok_o .. consumed_length_o| out_valid_o / out_ready_i
//
// One character is taken per cycle; the scanner state updates in the cycle
// of acceptance. The result of a string appears in the cycle after its last
// character. Input stalls only while a result waits and out_ready_i is low.
// Reset clears the scanner state and empties the result register.
module compact_timestamp_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     char_in_i,
  input  logic                           last_char_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           parse_ok_o,
  output logic signed [ctp_pkg::YearWidth-1:0]  year_value_o,
  output logic [ctp_pkg::FieldWidth-1:0]  month_value_o,
  output logic [ctp_pkg::FieldWidth-1:0]  day_value_o,
  output logic [ctp_pkg::FieldWidth-1:0]  hour_value_o,
  output logic [ctp_pkg::FieldWidth-1:0]  minute_value_o,
  output logic [ctp_pkg::FieldWidth-1:0]  second_value_o,
  output logic [ctp_pkg::LengthWidth-1:0] consumed_length_o
);
  import ctp_pkg::*;

  scan_state_t nxt;
  logic        accept;
  logic        ok;
  logic [YearWidth-1:0] mag;

  logic out_valid_q, out_valid_d;
  logic parse_ok_q;
  logic [YearWidth-1:0]   year_q;
  logic [FieldWidth-1:0]  month_q, day_q, hour_q, minute_q, second_q;
  logic [LengthWidth-1:0] length_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ctp_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_in_i   (char_in_i),
    .last_char_i (last_char_i),
    .state_d_o   (nxt)
  );

  assign ok  = !nxt.error_seen && (nxt.count >= CountTail);
  assign mag = YearWidth'(nxt.accum);

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && last_char_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_char_i) begin
      parse_ok_q <= ok;
      if (ok) begin
        year_q   <= nxt.negative ? (~mag + 1'b1) : mag;
        month_q  <= pair_value(nxt.window[0], nxt.window[1]);
        day_q    <= pair_value(nxt.window[2], nxt.window[3]);
        hour_q   <= pair_value(nxt.window[4], nxt.window[5]);
        minute_q <= pair_value(nxt.window[6], nxt.window[7]);
        second_q <= pair_value(nxt.window[8], nxt.window[9]);
        length_q <= LengthWidth'(nxt.count + CountWidth'(nxt.negative));
      end else begin
        year_q   <= '0;
        month_q  <= '0;
        day_q    <= '0;
        hour_q   <= '0;
        minute_q <= '0;
        second_q <= '0;
        length_q <= '0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign parse_ok_o        = parse_ok_q;
  assign year_value_o      = signed'(year_q);
  assign month_value_o     = month_q;
  assign day_value_o       = day_q;
  assign hour_value_o      = hour_q;
  assign minute_value_o    = minute_q;
  assign second_value_o    = second_q;
  assign consumed_length_o = length_q;

endmodule

// ===== tb/timestamp_checker.sv =====
// Checker for the compact timestamp parser: tracks each string and scores every result.
module timestamp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [7:0]                      char_in_i,
  input  logic                            last_char_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            parse_ok_i,
  input  logic [ctp_pkg::YearWidth-1:0]   year_value_i,
  input  logic [ctp_pkg::FieldWidth-1:0]  month_value_i,
  input  logic [ctp_pkg::FieldWidth-1:0]  day_value_i,
  input  logic [ctp_pkg::FieldWidth-1:0]  hour_value_i,
  input  logic [ctp_pkg::FieldWidth-1:0]  minute_value_i,
  input  logic [ctp_pkg::FieldWidth-1:0]  second_value_i,
  input  logic [ctp_pkg::LengthWidth-1:0] consumed_length_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import ctp_pkg::*;

  typedef struct packed {
    logic                   ok;
    logic [YearWidth-1:0]   year;
    logic [FieldWidth-1:0]  month;
    logic [FieldWidth-1:0]  day;
    logic [FieldWidth-1:0]  hour;
    logic [FieldWidth-1:0]  minute;
    logic [FieldWidth-1:0]  second;
    logic [LengthWidth-1:0] length;
  } stamp_t;

  digit_t                tail_digits [TailDigits];
  logic [CountWidth-1:0] digits_seen;
  logic [AccumWidth-1:0] year_sum;
  logic                  minus_seen;
  logic                  first_char;
  logic                  bad_string;

  stamp_t expected_stamps [$];
  stamp_t seen_stamp;
  stamp_t want_stamp;

  function automatic string stamp_text(stamp_t s);
    return $sformatf("ok=%0d year=%0d %0d-%0d %0d:%0d:%0d len=%0d", s.ok,
                     $signed(s.year), s.month, s.day, s.hour, s.minute, s.second,
                     s.length);
  endfunction

  task automatic clear_scan();
    foreach (tail_digits[i]) tail_digits[i] = '0;
    digits_seen = '0;
    year_sum    = '0;
    minus_seen  = 1'b0;
    first_char  = 1'b1;
    bad_string  = 1'b0;
  endtask

  task automatic scan_char(input logic [7:0] c);
    logic was_first;
    was_first  = first_char;
    first_char = 1'b0;
    if (bad_string) return;
    if (was_first && c == CharMinus) begin
      minus_seen = 1'b1;
      return;
    end
    if (c < CharZero || c > CharNine) begin
      bad_string = 1'b1;
      return;
    end
    if (digits_seen >= CountTail) year_sum = AccumWidth'(year_sum * 10 + tail_digits[0]);
    for (int i = 0; i < TailDigits - 1; i++) tail_digits[i] = tail_digits[i+1];
    tail_digits[TailDigits-1] = digit_t'(c - CharZero);
    if (digits_seen != CountSat) digits_seen = digits_seen + 1'b1;
    if (digits_seen > CountMax) bad_string = 1'b1;
  endtask

  function automatic logic [FieldWidth-1:0] digit_pair(int k);
    return FieldWidth'(tail_digits[k] * 10 + tail_digits[k+1]);
  endfunction

  function automatic stamp_t parsed_stamp();
    stamp_t      s;
    logic [31:0] signed_year;
    s = '0;
    if (!bad_string && digits_seen >= CountTail) begin
      signed_year = minus_seen ? 32'd0 - {2'b00, year_sum} : {2'b00, year_sum};
      s.ok     = 1'b1;
      s.year   = signed_year[YearWidth-1:0];
      s.month  = digit_pair(0);
      s.day    = digit_pair(2);
      s.hour   = digit_pair(4);
      s.minute = digit_pair(6);
      s.second = digit_pair(8);
      s.length = LengthWidth'(digits_seen + minus_seen);
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      expected_stamps.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_stamp = {parse_ok_i, year_value_i, month_value_i, day_value_i, hour_value_i,
                      minute_value_i, second_value_i, consumed_length_i};
        if (expected_stamps.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: %s", stamp_text(seen_stamp));
        end else begin
          want_stamp = expected_stamps.pop_front();
          if (seen_stamp != want_stamp) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("result mismatch: expected %s, got %s", stamp_text(want_stamp),
                       stamp_text(seen_stamp));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        scan_char(char_in_i);
        if (last_char_i) begin
          expected_stamps.push_back(parsed_stamp());
          clear_scan();
        end
      end
      pending_o = expected_stamps.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives timestamp strings into the parser and reports the verdict.
module testbench;
  import ctp_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             char_in;
  logic                   last_char;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   parse_ok;
  logic [YearWidth-1:0]   year_value;
  logic [FieldWidth-1:0]  month_value;
  logic [FieldWidth-1:0]  day_value;
  logic [FieldWidth-1:0]  hour_value;
  logic [FieldWidth-1:0]  minute_value;
  logic [FieldWidth-1:0]  second_value;
  logic [LengthWidth-1:0] consumed_length;
  int                     fail_count;
  int                     pending_stamps;

  int                     send_gap_pct;
  int                     take_stall_pct = 0;
  int                     chars_sent;
  logic [7:0]             text [$];

  always #6 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= take_stall_pct);

  compact_timestamp_parser u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .char_in_i         (char_in),
    .last_char_i       (last_char),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .parse_ok_o        (parse_ok),
    .year_value_o      (year_value),
    .month_value_o     (month_value),
    .day_value_o       (day_value),
    .hour_value_o      (hour_value),
    .minute_value_o    (minute_value),
    .second_value_o    (second_value),
    .consumed_length_o (consumed_length)
  );

  timestamp_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .char_in_i         (char_in),
    .last_char_i       (last_char),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .parse_ok_i        (parse_ok),
    .year_value_i      (year_value),
    .month_value_i     (month_value),
    .day_value_i       (day_value),
    .hour_value_i      (hour_value),
    .minute_value_i    (minute_value),
    .second_value_i    (second_value),
    .consumed_length_i (consumed_length),
    .fail_count_o      (fail_count),
    .pending_o         (pending_stamps)
  );

  task automatic send_char(input logic [7:0] c, input logic is_last);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid  = 1'b1;
    char_in   = c;
    last_char = is_last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_stamps != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] any_digit();
    return CharZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c >= CharZero && c <= CharNine);
    return c;
  endfunction

  task automatic add_digits(input int n);
    int fill;
    fill = $urandom_range(0, 7);
    repeat (n) begin
      case (fill)
        0:       text.push_back(CharZero);
        1:       text.push_back(CharNine);
        default: text.push_back(any_digit());
      endcase
    end
  endtask

  task automatic build_stamp(input int year_digits);
    if ($urandom_range(0, 1)) text.push_back(CharMinus);
    add_digits(year_digits + TailDigits);
  endtask

  function automatic int pick_year_digits();
    return $urandom_range(0, 3) == 0 ? MaxYearDigits : $urandom_range(0, MaxYearDigits);
  endfunction

  task automatic build_broken();
    int pos;
    case ($urandom_range(0, 4))
      0: begin
        build_stamp(pick_year_digits());
        pos = $urandom_range(0, text.size() - 1);
        text[pos] = non_digit();
      end
      1: begin
        if ($urandom_range(0, 1)) text.push_back(CharMinus);
        add_digits($urandom_range(0, TailDigits - 1));
        if (text.size() == 0) text.push_back(CharMinus);
      end
      2: build_stamp($urandom_range(MaxYearDigits + 1, MaxYearDigits + 3));
      3: begin
        build_stamp(pick_year_digits());
        pos = $urandom_range(1, text.size());
        text.insert(pos, CharMinus);
      end
      default: add_digits($urandom_range(20, 34));
    endcase
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    char_in   = '0;
    last_char = 1'b0;
    send_gap_pct = 0;
    chars_sent   = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    text.push_back(CharMinus);
    send_text();
    text.push_back(8'hFF);
    send_text();
    text.push_back(8'h00);
    send_text();
    text.push_back(CharMinus);
    repeat (TailDigits + 1) text.push_back(CharZero);
    send_text();
    repeat (TailDigits) text.push_back(CharNine);
    send_text();

    // hold off until every result of the directed strings is back
    wait_drained();

    while (chars_sent < 920) begin
      case ((chars_sent / 150) % 4)
        0: begin send_gap_pct = 0;  take_stall_pct = 0;  end
        1: begin send_gap_pct = 72; take_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  take_stall_pct = 72; end
        default: begin send_gap_pct = 10; take_stall_pct = 10; end
      endcase
      case ($urandom_range(0, 99)) inside
        [0:64]:  build_stamp(pick_year_digits());
        [65:84]: build_broken();
        default: repeat ($urandom_range(1, 22)) text.push_back(8'($urandom_range(0, 255)));
      endcase
      send_text();
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
